>>> src/aes_ctr_byte_stream_decrypt_core_macros.svh
// Assertion macros for the byte-stream CTR decrypt core.
`ifndef AES_CTR_BYTE_STREAM_DECRYPT_CORE_MACROS_SVH
`define AES_CTR_BYTE_STREAM_DECRYPT_CORE_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is active.
`define ACBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert that a condition implies another one in the cycle after it holds.
`define ACBS_ASSERT_NEXT(lbl, cond, expr, msg) \
  `ACBS_ASSERT(lbl, (cond) |=> (expr), msg)

`endif

>>> src/acbs_pkg.sv
// Shared types, constants and AES functions for the byte-stream CTR decrypt core.
package acbs_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [4:0] BlockBytes = 5'd16;
  localparam logic [3:0] LastRound = 4'd10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_UPPER = 3'd0,
    REG_KEY_LOWER = 3'd1,
    REG_IV_UPPER  = 3'd2,
    REG_IV_LOWER  = 3'd3,
    REG_DEC_EN    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    BS_IDLE,
    BS_AES
  } back_state_e;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       start_of_stream;
  } item_t;

  typedef struct packed {
    logic         start;
    logic [127:0] ctr;
  } aes_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 sits in bits 127:120.
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [3:0] rnd);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {SBOX[rk[23:16]] ^ rcon(rnd), SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = SBOX[b[r+4*((c+r)%4)]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

endpackage

>>> src/acbs_front.sv
// Input queue that accepts byte transactions ahead of the keystream back end.
module acbs_front import acbs_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  head_valid_o,
  output item_t head_o,
  input  logic  pop_i
);
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o   = (cnt_q != Full);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && head_valid_o;

  always_comb begin
    wr_d  = push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> src/acbs_aes.sv
// Iterative AES-128 encryptor, one round per cycle with on-the-fly key expansion.
module acbs_aes import acbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  aes_req_t     req_i,
  input  logic [127:0] key_i,
  output logic         done_o,
  output logic [127:0] block_o
);
  logic [127:0] st_q, st_d, rk_q, rk_d, rk_n;
  logic [3:0] rnd_q, rnd_d;
  logic busy_q, busy_d, done_q, done_d;

  assign rk_n = key_next(rk_q, rnd_q);

  always_comb begin
    st_d   = st_q;
    rk_d   = rk_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      st_d   = req_i.ctr ^ key_i;
      rk_d   = key_i;
      rnd_d  = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      st_d  = aes_round(st_q, rnd_q == LastRound) ^ rk_n;
      rk_d  = rk_n;
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == LastRound) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o  = done_q;
  assign block_o = st_q;
endmodule

>>> src/acbs_back.sv
// Back end: counter, keystream block, byte position and output register.
module acbs_back import acbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         head_valid_i,
  input  item_t        head_i,
  output logic         pop_o,
  input  logic [127:0] iv_i,
  input  logic         dec_en_i,
  output aes_req_t     aes_req_o,
  input  logic         aes_done_i,
  input  logic [127:0] aes_block_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   plain_byte_o
);
  back_state_e state_q, state_d;
  logic [127:0] ctr_q, ctr_d, ctr_src, ks_q, ks_d;
  logic [4:0] pos_q, pos_d;
  logic sos_done_q, sos_done_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] plain_q, plain_d, ks_byte;
  logic out_free, sos_pending, need_block, start, emit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign sos_pending = head_i.start_of_stream && !sos_done_q;
  assign need_block  = dec_en_i && (sos_pending || pos_q[4]);
  assign ctr_src     = sos_pending ? iv_i : ctr_q;
  assign ks_byte     = ks_q[8*(5'd15 - {1'b0, pos_q[3:0]}) +: 8];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: if (head_valid_i && need_block) state_d = BS_AES;
      BS_AES:  if (aes_done_i) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        start = head_valid_i && need_block;
        emit  = head_valid_i && !need_block && out_free;
      end
      BS_AES:  ;
      default: ;
    endcase
  end

  always_comb begin
    ctr_d       = ctr_q;
    ks_d        = ks_q;
    pos_d       = pos_q;
    sos_done_d  = sos_done_q;
    plain_d     = plain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (start) begin
      ctr_d      = ctr_src + 128'd1;
      sos_done_d = 1'b1;
    end
    if (aes_done_i) begin
      ks_d  = aes_block_i;
      pos_d = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      sos_done_d  = 1'b0;
      if (dec_en_i) begin
        plain_d = head_i.cipher_byte ^ ks_byte;
        pos_d   = {1'b0, pos_q[3:0]} + 5'd1;
      end else begin
        plain_d = head_i.cipher_byte;
        if (head_i.start_of_stream) begin
          ctr_d = iv_i;
          pos_d = BlockBytes;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q    <= ks_d;
    plain_q <= plain_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      ctr_q       <= '0;
      pos_q       <= BlockBytes;
      sos_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      pos_q       <= pos_d;
      sos_done_q  <= sos_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pop_o           = emit;
  assign aes_req_o.start = start;
  assign aes_req_o.ctr   = ctr_src;
  assign out_valid_o     = out_valid_q;
  assign plain_byte_o    = plain_q;
endmodule

>>> src/aes_ctr_byte_stream_decrypt_core.sv
// Top level of the AES-128 CTR byte-stream decrypt core.
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one ciphertext byte and a
//    start-of-stream flag per transaction; output channel carries one plaintext
//    byte per transaction, in order.
//  - Configuration channel writes key, IV and enable by register index; it is
//    always ready. Write it only while the core is idle.
//  - Each byte is registered in the input queue and then in the output register.
//  - Throughput: one byte per cycle within a block while the receiver takes the
//    output; each new block (every 16 bytes and at each start of stream) stalls
//    the stream while the iterative AES unit, which runs one round per cycle,
//    computes it and the keystream register is loaded.
//  - With decryption off, bytes pass unchanged, one per cycle while the receiver takes them.
//  - Reset clears key, IV, enable and counter, empties the input queue and
//    marks the keystream block as used up.
//  - When the receiver stalls, the output register holds its byte and the input
//    queue fills, then in_ready_o drops.
module aes_ctr_byte_stream_decrypt_core import acbs_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          cipher_byte_i,
  input  logic                start_of_stream_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          plain_byte_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic dec_en_q;
  item_t in_item, head;
  logic head_valid, pop;
  aes_req_t aes_req;
  logic aes_done;
  logic [127:0] aes_block;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
      dec_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY_UPPER: key_hi_q <= cfg_data_i;
        REG_KEY_LOWER: key_lo_q <= cfg_data_i;
        REG_IV_UPPER:  iv_hi_q  <= cfg_data_i;
        REG_IV_LOWER:  iv_lo_q  <= cfg_data_i;
        REG_DEC_EN:    dec_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.cipher_byte     = cipher_byte_i;
  assign in_item.start_of_stream = start_of_stream_i;

  acbs_front #(.QueueDepth(QueueDepth)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  acbs_aes u_aes (
    .clk_i,
    .rst_ni,
    .req_i   (aes_req),
    .key_i   ({key_hi_q, key_lo_q}),
    .done_o  (aes_done),
    .block_o (aes_block)
  );

  acbs_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .iv_i         ({iv_hi_q, iv_lo_q}),
    .dec_en_i     (dec_en_q),
    .aes_req_o    (aes_req),
    .aes_done_i   (aes_done),
    .aes_block_i  (aes_block),
    .out_valid_o,
    .out_ready_i,
    .plain_byte_o
  );
endmodule

>>> src/acbs_checker.sv
// Port-level checker for the CTR decrypt core, bound to the top level.
`include "aes_ctr_byte_stream_decrypt_core_macros.svh"

module acbs_checker import acbs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [7:0]          plain_byte_o,
  input logic                cfg_ready_o
);
  `ACBS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(plain_byte_o), "output transaction dropped or changed while stalled")
  `ACBS_ASSERT(a_cfg_ready, cfg_ready_o, "configuration channel not ready")
  `ACBS_ASSERT_NEXT(a_in_space_kept, in_ready_o && !in_valid_i, in_ready_o, "input queue lost space without a transaction")
endmodule

bind aes_ctr_byte_stream_decrypt_core acbs_checker u_acbs_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .plain_byte_o,
  .cfg_ready_o
);

>>> test/testbench.sv
// Self-checking testbench for the AES-128 CTR byte-stream decrypt core.
`timescale 1ns / 1ps

module testbench;
  import acbs_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic [7:0] cipher_byte;
    logic       start_of_stream;
  } byte_txn_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          cipher_byte_i;
  logic                start_of_stream_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          plain_byte_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  aes_ctr_byte_stream_decrypt_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cipher_byte_i     (cipher_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .plain_byte_o      (plain_byte_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Predictor state
  logic [127:0] key_q, iv_q, ctr_q, ks_q;
  logic         dec_en_q;
  logic [4:0]   ks_pos_q;

  byte_txn_t   pending_bytes[$];
  logic [7:0]  expected_plain[$];
  int          fail_count;
  int          idle_cycles;
  bit          calm, out_hold, in_acc;
  int          hold_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                  input logic [127:0] blk);
    logic [7:0]   rk [176];
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   t0, t1, t2, t3, k, a0, a1, a2, a3, all;
    logic [7:0]   rc;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t0 = rk[4*i-4]; t1 = rk[4*i-3]; t2 = rk[4*i-2]; t3 = rk[4*i-1];
      if (i % 4 == 0) begin
        k = t0;
        t0 = SBOX[t1] ^ rc;
        t1 = SBOX[t2];
        t2 = SBOX[t3];
        t3 = SBOX[k];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      rk[4*i]   = rk[4*i-16] ^ t0;
      rk[4*i+1] = rk[4*i-15] ^ t1;
      rk[4*i+2] = rk[4*i-14] ^ t2;
      rk[4*i+3] = rk[4*i-13] ^ t3;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[j+4*c] = SBOX[s[j+4*((c+j)%4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic logic [7:0] decrypt_byte(input byte_txn_t txn);
    logic [7:0] b;
    b = txn.cipher_byte;
    if (txn.start_of_stream) begin
      ctr_q = iv_q;
      ks_pos_q = 5'd16;
    end
    if (dec_en_q) begin
      if (ks_pos_q >= 5'd16) begin
        ks_q = aes128_encrypt(key_q, ctr_q);
        ctr_q = ctr_q + 128'd1;
        ks_pos_q = 5'd0;
      end
      b ^= ks_q[127 - 8*ks_pos_q[3:0] -: 8];
      ks_pos_q = ks_pos_q + 5'd1;
    end
    return b;
  endfunction

  // Driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        void'(pending_bytes.pop_front());
      end
      if (!(in_valid_i && !in_acc)) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
          in_valid_i <= 1'b1;
          cipher_byte_i <= pending_bytes[0].cipher_byte;
          start_of_stream_i <= pending_bytes[0].start_of_stream;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= out_hold ? 1'b0 : (calm || $urandom_range(99) >= 6);
      end
    end
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_acc <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_plain.push_back(decrypt_byte('{cipher_byte_i, start_of_stream_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_plain.size() == 0) begin
          $error("unexpected transaction: plain_byte %0h", plain_byte_o);
          fail_count++;
        end else begin
          if (plain_byte_o !== expected_plain[0]) begin
            $error("plain_byte expected %0h actual %0h", expected_plain[0], plain_byte_o);
            fail_count++;
          end
          void'(expected_plain.pop_front());
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (pending_bytes.size() == 0 && expected_plain.size() == 0) || out_hold ||
          hold_cycles > 0) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > StallLimit) begin
        $display("aes_ctr_byte_stream_decrypt_core verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_KEY_UPPER: key_q[127:64] = data;
      REG_KEY_LOWER: key_q[63:0] = data;
      REG_IV_UPPER:  iv_q[127:64] = data;
      REG_IV_LOWER:  iv_q[63:0] = data;
      REG_DEC_EN:    dec_en_q = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || expected_plain.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [127:0] key, input logic [127:0] iv,
                          input logic en);
    write_reg(REG_KEY_UPPER, key[127:64]);
    write_reg(REG_KEY_LOWER, key[63:0]);
    write_reg(REG_IV_UPPER, iv[127:64]);
    write_reg(REG_IV_LOWER, iv[63:0]);
    write_reg(REG_DEC_EN, {63'd0, en});
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sos);
    pending_bytes.push_back('{b, sos});
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic random_streams(input int count);
    int n;
    n = 0;
    while (n < count) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(40, 1);
      for (int i = 0; i < len; i++) begin
        push_byte(8'($urandom_range(255)), i == 0 || $urandom_range(99) == 0);
        n++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cipher_byte_i = '0;
    start_of_stream_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KEY_UPPER;
    cfg_data_i = '0;
    key_q = '0;
    iv_q = '0;
    ctr_q = '0;
    ks_q = '0;
    dec_en_q = 1'b0;
    ks_pos_q = 5'd16;
    fail_count = 0;
    idle_cycles = 0;
    calm = 1'b0;
    out_hold = 1'b0;
    in_acc = 1'b0;
    hold_cycles = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pass-through at reset defaults, extremes of the byte
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h5a, 1'b0);
    wait_drained();

    // FIPS-197 key, counter wrap from all ones
    set_regs(128'h000102030405060708090a0b0c0d0e0f, {128{1'b1}}, 1'b1);
    for (int i = 0; i < 20; i++) push_byte(i == 3 ? 8'hff : 8'h00, i == 0);
    wait_drained();

    // Extreme key values, IV change mid-stream
    set_regs({128{1'b1}}, '0, 1'b1);
    for (int i = 0; i < 18; i++) push_byte(8'($urandom_range(255)), i == 0 || i == 17);
    wait_drained();
    write_reg(REG_IV_LOWER, 64'h0123456789abcdef);
    write_reg(REG_KEY_UPPER, '0);
    for (int i = 0; i < 20; i++) push_byte(8'($urandom_range(255)), i == 5);
    wait_drained();

    // Disabled mode with start flags
    write_reg(REG_DEC_EN, 64'd0);
    for (int i = 0; i < 6; i++) push_byte(8'($urandom_range(255)), i[0]);
    wait_drained();

    // Random streams under random settings
    for (int phase = 0; phase < 6; phase++) begin
      set_regs(rand128(), phase == 2 ? {{64{1'b1}}, 64'hffffffff_fffffff8} : rand128(),
               phase != 4);
      calm = (phase == 3);
      random_streams(200);
      if (phase == 1) begin
        while (pending_bytes.size() > 150) @(posedge clk_i);
        @(negedge clk_i);
        out_hold = 1'b1;
        hold_cycles = 300;
        out_hold = 1'b0;
      end
      wait_drained();
    end
    calm = 1'b0;
    random_streams(250);
    wait_drained();

    if (fail_count == 0) begin
      $display("aes_ctr_byte_stream_decrypt_core verification clean");
    end else begin
      $display("aes_ctr_byte_stream_decrypt_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/acbs_pkg.sv
src/acbs_front.sv
src/acbs_aes.sv
src/acbs_back.sv
src/aes_ctr_byte_stream_decrypt_core.sv
src/acbs_checker.sv
test/testbench.sv
